[hdl/mkle_pkg.sv]
`default_nettype none
package mkle_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIST_W  = 33;
  localparam int unsigned LINK_W  = DIST_W + 1;
  localparam int unsigned CFG_W   = 10;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic REG_NUM_POINTS     = 1'b0;
  localparam logic REG_NUM_SATELLITES = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] num_points;
    logic [CFG_W-1:0] num_satellites;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ORIGIN,
    ST_ORIGIN_WAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_MARK,
    ST_SEL_READ,
    ST_SEL_LOAD,
    ST_SEL_SCAN,
    ST_SEL_DRAIN,
    ST_SEL_CHECK,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

[hdl/mst_kth_largest_edge.sv]
// Channel  Direction  Handshake               Beat contents
// in       sink       in_valid_i / in_stall_o cmd_i, x_coord_i, y_coord_i
// out      source     out_valid_o/out_stall_i sq_range_o
// cfg      sink       APB psel/penable        num_points @0x0, num_satellites @0x4
//
// A load beat stores the point; loads beyond MAX_POINTS drop.
// A compute beat runs Prim over n points: n-1 passes over the point store
// (one point-store read per cycle), then a rank select over the n-1 tree edges
// of up to n-1 rounds; if num_satellites >= n it skips both and returns 0.
// Reset clears control only; the stores hold garbage until written.
// The input stalls for the whole compute; the result waits in the output
// register while new loads are taken.
`default_nettype none
module mst_kth_largest_edge
  import mkle_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 512
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      cmd_i,
  input  wire logic signed [COORD_W-1:0] x_coord_i,
  input  wire logic signed [COORD_W-1:0] y_coord_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic             [DIST_W-1:0]  sq_range_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic        [2:0]         paddr,
  input  wire logic        [31:0]        pwdata,
  output logic             [31:0]        prdata,
  output logic                           pready
);

  cfg_t              cfg;
  logic              busy, res_valid, res_free;
  logic [DIST_W-1:0] res, out_q;
  logic              out_valid_q, out_valid_d;

  mkle_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mkle_core #(.MAX_POINTS(MAX_POINTS)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .x_i         (x_coord_i),
    .y_i         (y_coord_i),
    .busy_o      (busy),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output slot is free when empty or being drained this cycle.
  assign res_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_free) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result until the sink takes it.
  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign sq_range_o  = out_q;

endmodule
`default_nettype wire

[hdl/mkle_cfg.sv]
`default_nettype none
module mkle_cfg
  import mkle_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        REG_NUM_POINTS:     cfg_d.num_points     = pwdata[CFG_W-1:0];
        REG_NUM_SATELLITES: cfg_d.num_satellites = pwdata[CFG_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_points     <= CFG_W'(1);
      cfg_q.num_satellites <= CFG_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUM_POINTS:     prdata = 32'(cfg_q.num_points);
      REG_NUM_SATELLITES: prdata = 32'(cfg_q.num_satellites);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[hdl/mkle_dist.sv]
`default_nettype none
module mkle_dist
  import mkle_pkg::*;
#(
  parameter int unsigned TAG_W = 43
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire logic signed [COORD_W-1:0] ax_i,
  input  wire logic signed [COORD_W-1:0] ay_i,
  input  wire logic signed [COORD_W-1:0] bx_i,
  input  wire logic signed [COORD_W-1:0] by_i,
  input  wire logic        [TAG_W-1:0]   tag_i,
  output logic                           valid_o,
  output logic             [TAG_W-1:0]   tag_o,
  output logic             [DIST_W-1:0]  sq_o,
  output logic                           busy_o
);

  logic signed [COORD_W:0] dx, dy;
  logic        [COORD_W:0] adx, ady;
  logic [COORD_W-1:0]   ax_q, ay_q;
  logic [2*COORD_W-1:0] sx_q, sy_q;
  logic [DIST_W-1:0]    sq_q;
  logic [TAG_W-1:0]     t1_q, t2_q, t3_q;
  logic v1_q, v2_q, v3_q;

  // Differences span 17 bits; magnitude fits 16 bits unsigned.
  assign dx  = {ax_i[COORD_W-1], ax_i} - {bx_i[COORD_W-1], bx_i};
  assign dy  = {ay_i[COORD_W-1], ay_i} - {by_i[COORD_W-1], by_i};
  assign adx = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
  assign ady = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= adx[COORD_W-1:0];
    ay_q <= ady[COORD_W-1:0];
    t1_q <= tag_i;
    sx_q <= ax_q * ax_q;
    sy_q <= ay_q * ay_q;
    t2_q <= t1_q;
    sq_q <= DIST_W'(sx_q) + DIST_W'(sy_q);
    t3_q <= t2_q;
  end

  assign valid_o = v3_q;
  assign tag_o   = t3_q;
  assign sq_o    = sq_q;
  assign busy_o  = v1_q | v2_q | v3_q;

endmodule
`default_nettype wire

[hdl/mkle_core.sv]
`default_nettype none
module mkle_core
  import mkle_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 512
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  cfg_t                           cfg_i,
  input  wire logic                      in_valid_i,
  input  wire logic                      cmd_i,
  input  wire logic signed [COORD_W-1:0] x_i,
  input  wire logic signed [COORD_W-1:0] y_i,
  output logic                           busy_o,
  input  wire logic                      res_free_i,
  output logic                           res_valid_o,
  output logic             [DIST_W-1:0]  res_o
);

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned TAG_W = AW + LINK_W;

  logic [COORD_W-1:0] x_mem [MAX_POINTS];
  logic [COORD_W-1:0] y_mem [MAX_POINTS];
  logic [LINK_W-1:0]  bl_mem [MAX_POINTS];
  logic [DIST_W-1:0]  tw_mem [MAX_POINTS];

  state_e state_q, state_d;
  logic [CW-1:0]      load_cnt_q, load_cnt_d;
  logic [AW-1:0]      scan_q, scan_d, pick_q, pick_d, pickn_q, pickn_d;
  logic [AW-1:0]      edge_q, edge_d, sel_j_q, sel_j_d, rank_q, rank_d;
  logic               first_q, first_d, found_q, found_d;
  logic [DIST_W-1:0]  best_q, best_d, res_q, res_d, wj_q;
  logic signed [COORD_W-1:0] px_q, py_q, x_rd, y_rd;
  logic [LINK_W-1:0]  bl_rd;
  logic [DIST_W-1:0]  tw_rd;
  logic               rv_q, trv_q;
  logic [AW-1:0]      ridx_q, tidx_q;

  logic [CW-1:0]      n_w;
  logic [CFG_W-1:0]   k_w;
  logic               no_work;
  logic [AW-1:0]      last_w, sel_last, sel_idx;

  logic               xy_we, bl_we, tw_we, rd_issue;
  logic [AW-1:0]      xy_raddr, tw_raddr, bl_waddr;
  logic [LINK_W-1:0]  bl_wdata;

  logic               d_valid, d_busy, d_joined;
  logic [TAG_W-1:0]   d_tag;
  logic [DIST_W-1:0]  d_sq, d_old, d_new;
  logic [AW-1:0]      d_idx;

  assign n_w      = (32'(cfg_i.num_points) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                         : CW'(cfg_i.num_points);
  assign k_w      = (cfg_i.num_satellites == '0) ? CFG_W'(1) : cfg_i.num_satellites;
  assign no_work  = 32'(k_w) >= 32'(n_w);
  assign last_w   = AW'(n_w - CW'(1));
  assign sel_last = AW'(n_w - CW'(2));
  assign sel_idx  = AW'(32'(n_w) - 32'(k_w) - 32'd1);

  mkle_dist #(.TAG_W(TAG_W)) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rv_q),
    .ax_i    (x_rd),
    .ay_i    (y_rd),
    .bx_i    (px_q),
    .by_i    (py_q),
    .tag_i   ({ridx_q, bl_rd}),
    .valid_o (d_valid),
    .tag_o   (d_tag),
    .sq_o    (d_sq),
    .busy_o  (d_busy)
  );

  assign d_idx    = d_tag[TAG_W-1:LINK_W];
  assign d_joined = first_q ? 1'b0 : d_tag[LINK_W-1];
  assign d_old    = d_tag[DIST_W-1:0];
  assign d_new    = (first_q || d_sq < d_old) ? d_sq : d_old;

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    scan_d     = scan_q;
    pick_d     = pick_q;
    pickn_d    = pickn_q;
    edge_d     = edge_q;
    sel_j_d    = sel_j_q;
    rank_d     = rank_q;
    first_d    = first_q;
    found_d    = found_q;
    best_d     = best_q;
    res_d      = res_q;
    xy_we      = 1'b0;
    bl_we      = 1'b0;
    tw_we      = 1'b0;
    rd_issue   = 1'b0;
    xy_raddr   = scan_q;
    tw_raddr   = scan_q;
    bl_waddr   = d_idx;
    bl_wdata   = {1'b0, d_new};
    res_valid_o = 1'b0;

    // Relax one link and track the nearest free point.
    if (d_valid && !d_joined) begin
      bl_we = 1'b1;
      if (!found_q || d_new < best_q) begin
        best_d  = d_new;
        pickn_d = d_idx;
        found_d = 1'b1;
      end
    end

    // Rank the candidate edge with index as tie-break.
    if (trv_q && (tw_rd < wj_q || (tw_rd == wj_q && tidx_q < sel_j_q))) begin
      rank_d = rank_q + AW'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_LOAD) begin
            if (load_cnt_q != CW'(MAX_POINTS)) begin
              xy_we      = 1'b1;
              load_cnt_d = load_cnt_q + CW'(1);
            end
          end else begin
            load_cnt_d = '0;
            if (no_work) begin
              res_d   = '0;
              state_d = ST_DONE;
            end else begin
              pick_d  = '0;
              first_d = 1'b1;
              edge_d  = '0;
              state_d = ST_ORIGIN;
            end
          end
        end
      end
      ST_ORIGIN: begin
        xy_raddr = pick_q;
        state_d  = ST_ORIGIN_WAIT;
      end
      ST_ORIGIN_WAIT: begin
        scan_d  = AW'(1);
        found_d = 1'b0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        rd_issue = 1'b1;
        if (scan_q == last_w) begin
          state_d = ST_DRAIN;
        end else begin
          scan_d = scan_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rv_q && !d_busy) begin
          state_d = ST_MARK;
        end
      end
      ST_MARK: begin
        bl_we    = 1'b1;
        bl_waddr = pickn_q;
        bl_wdata = {1'b1, best_q};
        tw_we    = 1'b1;
        if (edge_q + AW'(1) == last_w) begin
          sel_j_d = '0;
          state_d = ST_SEL_READ;
        end else begin
          edge_d  = edge_q + AW'(1);
          pick_d  = pickn_q;
          first_d = 1'b0;
          state_d = ST_ORIGIN;
        end
      end
      ST_SEL_READ: begin
        tw_raddr = sel_j_q;
        state_d  = ST_SEL_LOAD;
      end
      ST_SEL_LOAD: begin
        scan_d  = '0;
        rank_d  = '0;
        state_d = ST_SEL_SCAN;
      end
      ST_SEL_SCAN: begin
        if (scan_q == sel_last) begin
          state_d = ST_SEL_DRAIN;
        end else begin
          scan_d = scan_q + AW'(1);
        end
      end
      ST_SEL_DRAIN: begin
        state_d = ST_SEL_CHECK;
      end
      ST_SEL_CHECK: begin
        if (rank_q == sel_idx) begin
          res_d   = wj_q;
          state_d = ST_DONE;
        end else begin
          sel_j_d = sel_j_q + AW'(1);
          state_d = ST_SEL_READ;
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      rv_q       <= 1'b0;
      trv_q      <= 1'b0;
      first_q    <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      load_cnt_q <= load_cnt_d;
      rv_q       <= rd_issue;
      trv_q      <= (state_q == ST_SEL_SCAN);
      first_q    <= first_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q  <= scan_d;
    pick_q  <= pick_d;
    pickn_q <= pickn_d;
    edge_q  <= edge_d;
    sel_j_q <= sel_j_d;
    rank_q  <= rank_d;
    best_q  <= best_d;
    res_q   <= res_d;
    ridx_q  <= scan_q;
    tidx_q  <= scan_q;
    if (state_q == ST_ORIGIN_WAIT) begin
      px_q <= x_rd;
      py_q <= y_rd;
    end
    if (state_q == ST_SEL_LOAD) begin
      wj_q <= tw_rd;
    end
  end

  // Point store
  always_ff @(posedge clk_i) begin
    if (xy_we) begin
      x_mem[load_cnt_q[AW-1:0]] <= x_i;
      y_mem[load_cnt_q[AW-1:0]] <= y_i;
    end
    x_rd <= x_mem[xy_raddr];
    y_rd <= y_mem[xy_raddr];
  end

  // Link store: best distance to the tree, joined flag on top
  always_ff @(posedge clk_i) begin
    if (bl_we) begin
      bl_mem[bl_waddr] <= bl_wdata;
    end
    bl_rd <= bl_mem[scan_q];
  end

  // Tree edge store
  always_ff @(posedge clk_i) begin
    if (tw_we) begin
      tw_mem[edge_q] <= best_q;
    end
    tw_rd <= tw_mem[tw_raddr];
  end

  assign busy_o = (state_q != ST_IDLE);
  assign res_o  = res_q;

  a_relax_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("link update outside a scan pass");

  a_mark_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK) |-> found_q)
    else $error("joining a point that was never picked");

  a_sel_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEL_CHECK && rank_q != sel_idx) |-> (sel_j_q != sel_last))
    else $error("edge selection ran past the last tree edge");

  a_scan_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ORIGIN) |-> (!rv_q && !d_busy))
    else $error("new pass started before the last one drained");

endmodule
`default_nettype wire
